// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(lbl, clk, rstn, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
    else $error("check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rstn, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
    else $error("check failed: next-cycle implication");

`endif

// ===== hdl/h4df_pkg.sv =====
// ----------------------------------------------------------------------------
// h4df_pkg
// Types and codes shared by the H4 packet deframer modules.
// ----------------------------------------------------------------------------
package h4df_pkg;

  typedef enum logic [1:0] {
    PH_TYPE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  localparam logic [1:0] ROLE_TYPE    = 2'd0;
  localparam logic [1:0] ROLE_HEADER  = 2'd1;
  localparam logic [1:0] ROLE_PAYLOAD = 2'd2;

  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_ACL   = 1'b1;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_TYPE = 2'd1;
  localparam logic [1:0] ERR_TOO_LONG = 2'd2;

  localparam logic [1:0] REG_EVENT_CODE = 2'd0;
  localparam logic [1:0] REG_ACL_CODE   = 2'd1;
  localparam logic [1:0] REG_MAX_ACL    = 2'd2;

  localparam logic [7:0]  EVENT_CODE_RST = 8'd4;
  localparam logic [7:0]  ACL_CODE_RST   = 8'd2;
  localparam logic [15:0] MAX_ACL_RST    = 16'd1021;

  localparam logic [2:0] EVT_HDR_LEN = 3'd2;
  localparam logic [2:0] ACL_HDR_LEN = 3'd4;

  typedef struct packed {
    logic [7:0]  event_code;
    logic [7:0]  acl_code;
    logic [15:0] max_acl;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  data;
    logic [1:0]  role;
    logic        kind;
    logic [16:0] offset;
    logic        last;
    logic [16:0] length;
    logic [1:0]  err;
  } result_t;

endpackage

// ===== hdl/h4df_core.sv =====
// ----------------------------------------------------------------------------
// h4df_core
// Packet state tracker: classifies each accepted byte and advances the state.
// ----------------------------------------------------------------------------
module h4df_core import h4df_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       byte_accept,
  input  logic [7:0] rx_byte,
  output result_t    result
);

  phase_t      phase_r, phase_nxt;
  logic        kind_r, kind_nxt;
  logic [15:0] seg_r, seg_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [7:0]  lo_r, lo_nxt;

  logic [2:0]  hdr;
  logic [15:0] pos;
  logic [15:0] pay;
  logic [16:0] cnt;

  assign hdr = kind_r ? ACL_HDR_LEN : EVT_HDR_LEN;

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    seg_nxt   = seg_r;
    plen_nxt  = plen_r;
    lo_nxt    = lo_r;
    pos       = seg_r;
    pay       = 16'd0;
    cnt       = {1'b0, seg_r} + 17'd1;

    result.data   = rx_byte;
    result.role   = ROLE_TYPE;
    result.kind   = kind_r;
    result.offset = 17'd0;
    result.last   = 1'b0;
    result.length = 17'd0;
    result.err    = ERR_NONE;

    case (phase_r)
      PH_HEADER: begin
        result.role = ROLE_HEADER;
        if (seg_r >= {13'd0, hdr}) begin
          pos = {13'd0, hdr - 3'd1};
        end
        if (pos == 16'd2) begin
          lo_nxt = rx_byte;
        end
        seg_nxt       = pos + 16'd1;
        result.offset = {1'b0, pos} + 17'd1;
        if (pos == {13'd0, hdr - 3'd1}) begin
          pay = kind_r ? {rx_byte, lo_r} : {8'd0, rx_byte};
          if (kind_r && (pay > cfg.max_acl)) begin
            result.err = ERR_TOO_LONG;
            phase_nxt  = PH_TYPE;
            kind_nxt   = KIND_EVENT;
            seg_nxt    = 16'd0;
            plen_nxt   = 16'd0;
          end else if (pay == 16'd0) begin
            result.last   = 1'b1;
            result.length = {14'd0, hdr};
            phase_nxt     = PH_TYPE;
            kind_nxt      = KIND_EVENT;
            seg_nxt       = 16'd0;
            plen_nxt      = 16'd0;
          end else begin
            plen_nxt  = pay;
            seg_nxt   = 16'd0;
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        result.role   = ROLE_PAYLOAD;
        result.offset = {14'd0, hdr} + cnt;
        if (cnt >= {1'b0, plen_r}) begin
          result.last   = 1'b1;
          result.length = {14'd0, hdr} + {1'b0, plen_r};
          phase_nxt     = PH_TYPE;
          kind_nxt      = KIND_EVENT;
          seg_nxt       = 16'd0;
          plen_nxt      = 16'd0;
        end else begin
          seg_nxt = cnt[15:0];
        end
      end
      default: begin
        // Unused phase codes behave like waiting for a type byte.
        seg_nxt  = 16'd0;
        plen_nxt = 16'd0;
        if ((rx_byte == cfg.event_code) || (rx_byte == cfg.acl_code)) begin
          kind_nxt    = (rx_byte == cfg.event_code) ? KIND_EVENT : KIND_ACL;
          result.kind = kind_nxt;
          phase_nxt   = PH_HEADER;
        end else begin
          result.err  = ERR_BAD_TYPE;
          result.kind = KIND_EVENT;
          kind_nxt    = KIND_EVENT;
          phase_nxt   = PH_TYPE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      kind_r  <= KIND_EVENT;
      seg_r   <= 16'd0;
      plen_r  <= 16'd0;
    end else if (byte_accept) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      seg_r   <= seg_nxt;
      plen_r  <= plen_nxt;
    end
  end

  // The low length byte is always rewritten before it is used.
  always_ff @(posedge clk) begin
    if (byte_accept) begin
      lo_r <= lo_nxt;
    end
  end

endmodule

// ===== hdl/h4df_out_stage.sv =====
// ----------------------------------------------------------------------------
// h4df_out_stage
// Result register with a one-entry skid buffer behind it.
// ----------------------------------------------------------------------------
module h4df_out_stage import h4df_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  result_t in_result,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_result
);

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    accept;
  logic    out_free;

  assign in_stall   = skid_valid_r;
  assign accept     = in_valid && !skid_valid_r;
  assign out_free   = !out_valid_r || !out_stall;
  assign out_valid  = out_valid_r;
  assign out_result = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (accept) begin
        out_data_nxt  = in_result;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      skid_data_nxt  = in_result;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

// ===== hdl/h4_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// h4_packet_deframer
// Splits a received UART byte stream into HCI H4 event and ACL packets and
// tags every byte with its role, packet kind, offset and end-of-packet mark.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  --------+--------------------------------------+-----------
//  in      | in_valid, in_stall, in_rx_byte       | byte in
//  out     | out_valid, out_stall, out_byte, ...  | tagged byte out
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | register write
//
// One byte is accepted per cycle while in_stall is low; its result is
// registered in the result register, or in the skid buffer on a stall.
// Reset (rst_n low, synchronous) clears the packet state and loads the
// default type codes (event 4, ACL 2) and the ACL limit 1021.
// A stalled result is held; a second byte parks in the skid buffer, after
// which in_stall rises until the result register drains.
// ----------------------------------------------------------------------------
module h4_packet_deframer import h4df_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_byte_role,
  output logic        out_packet_kind,
  output logic [16:0] out_byte_offset,
  output logic        out_last_of_packet,
  output logic [16:0] out_packet_length,
  output logic [1:0]  out_error_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg_r;
  result_t core_result;
  result_t stage_result;
  logic    byte_accept;

  assign cfg_ready   = 1'b1;
  assign byte_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.event_code <= EVENT_CODE_RST;
      cfg_r.acl_code   <= ACL_CODE_RST;
      cfg_r.max_acl    <= MAX_ACL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EVENT_CODE: cfg_r.event_code <= cfg_data[7:0];
        REG_ACL_CODE:   cfg_r.acl_code   <= cfg_data[7:0];
        REG_MAX_ACL:    cfg_r.max_acl    <= cfg_data;
        default: ;
      endcase
    end
  end

  h4df_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .byte_accept (byte_accept),
    .rx_byte     (in_rx_byte),
    .result      (core_result)
  );

  h4df_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_result  (core_result),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (stage_result)
  );

  assign out_byte           = stage_result.data;
  assign out_byte_role      = stage_result.role;
  assign out_packet_kind    = stage_result.kind;
  assign out_byte_offset    = stage_result.offset;
  assign out_last_of_packet = stage_result.last;
  assign out_packet_length  = stage_result.length;
  assign out_error_code     = stage_result.err;

endmodule

// ===== hdl/h4df_checker.sv =====
// ----------------------------------------------------------------------------
// h4df_checker
// Port-level checks on the deframer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module h4df_checker import h4df_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_rx_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic [1:0]  out_byte_role,
  input logic        out_packet_kind,
  input logic [16:0] out_byte_offset,
  input logic        out_last_of_packet,
  input logic [16:0] out_packet_length,
  input logic [1:0]  out_error_code,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [15:0] cfg_data
);

  logic unused_inputs;
  assign unused_inputs = in_valid ^ in_stall ^ (^in_rx_byte) ^ out_packet_kind
                       ^ cfg_valid ^ cfg_ready ^ (^cfg_index) ^ (^cfg_data);

  `CHK_NEXT(out_held, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_byte))

  `CHK_IMPLY(last_is_clean, clk, rst_n, out_valid && out_last_of_packet, (out_error_code == ERR_NONE) && (out_packet_length != 17'd0))

  `CHK_IMPLY(bad_type_shape, clk, rst_n, out_valid && (out_error_code == ERR_BAD_TYPE), (out_byte_role == ROLE_TYPE) && (out_byte_offset == 17'd0) && !out_last_of_packet)

  `CHK_IMPLY(payload_offset, clk, rst_n, out_valid && (out_byte_role == ROLE_PAYLOAD), out_byte_offset >= 17'd3)

endmodule

bind h4_packet_deframer h4df_checker u_h4df_checker (.*);
